// ===== rtl/dfa_pkg.sv =====
package dfa_pkg;

	// Table geometry
	localparam int STATE_COUNT  = 256;
	localparam int SYMBOL_COUNT = 256;
	localparam int BYTE_W       = 8;
	localparam int ST_AW        = (STATE_COUNT > (1 << BYTE_W)) ? BYTE_W : $clog2(STATE_COUNT);
	localparam int SYM_AW       = $clog2(SYMBOL_COUNT);
	localparam int TRAN_AW      = ST_AW + SYM_AW;
	localparam int TRAN_DEPTH   = 1 << TRAN_AW;
	localparam int ACC_DEPTH    = 1 << ST_AW;
	localparam int TRAN_W       = BYTE_W + 1;

	// Result queue
	localparam int OUT_DEPTH = 4;
	localparam int OUT_PW    = $clog2(OUT_DEPTH);
	localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);

	// Register defaults
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 8;
	localparam logic [BYTE_W-1:0] START_RESET    = 8'd0;
	localparam logic [BYTE_W-1:0] WILDCARD_RESET = 8'd46;

	typedef enum logic [1:0] {
		ACT_WR_TRAN   = 2'd0,
		ACT_WR_ACCEPT = 2'd1,
		ACT_MATCH     = 2'd2,
		ACT_END       = 2'd3
	} act_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_STATE = 1'b0,
		REG_WILDCARD    = 1'b1
	} reg_t;

	function automatic logic state_ok(input logic [BYTE_W-1:0] s);
		return 32'(s) < STATE_COUNT;
	endfunction

	function automatic logic symbol_ok(input logic [BYTE_W-1:0] s);
		return 32'(s) < SYMBOL_COUNT;
	endfunction

endpackage

// ===== rtl/dfa_ram.sv =====
module dfa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr_a,
	output logic [WIDTH-1:0] rdata_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write one entry, read two; a read at the write address returns the old data
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// ===== rtl/dfa_byte_matcher_wildcard.sv =====
// Table-driven DFA matcher with a wildcard fallback transition.
// Input channel (in_valid/in_ready) carries one item per handshake: action selects
// a transition write, an accept-mark write, one byte of a string, or an empty end.
// Output channel (out_valid/out_ready) carries one matched bit per finished string,
// i.e. per byte item with is_last_byte set and per empty-end item.
// Configuration: cfg_we writes start_state (index 0) or wildcard_symbol (index 1)
// in the same cycle; a start_state write also aborts any string in progress.
// Throughput: one item per cycle while in_ready is high. The transition RAM is read
// for the byte and for the wildcard at once; its registered data selects the next
// state, which feeds the address of the following byte in the same cycle.
// Result path: a result passes the transition read, the accept-mark read, then the
// result queue write before out_valid shows it.
// Reset: after arst_n releases, a clearing pass walks the transition and accept
// RAMs, one entry a cycle, over TRAN_DEPTH (65536) addresses; in_ready stays low then.
// Stall: results wait in a four-entry queue; outside the clearing pass, in_ready drops
// only while four results are in flight, so nothing is lost when out_ready is held low.
module dfa_byte_matcher_wildcard (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [1:0]                         action,
	input  logic [dfa_pkg::BYTE_W-1:0]         table_state,
	input  logic [dfa_pkg::BYTE_W-1:0]         table_symbol,
	input  logic [dfa_pkg::BYTE_W-1:0]         table_next,
	input  logic                               table_entry_valid,
	input  logic                               accept_value,
	input  logic [dfa_pkg::BYTE_W-1:0]         text_byte,
	input  logic                               is_last_byte,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               matched,
	input  logic                               cfg_we,
	input  logic [dfa_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [dfa_pkg::CFG_W-1:0]          cfg_data
);

	import dfa_pkg::*;

	// Registers
	logic [BYTE_W-1:0]  start_q, wild_q, cur_q;
	logic               rej_q;
	logic               clr_q;
	logic [TRAN_AW-1:0] clr_addr_q;

	logic               s1_valid, s1_end, s1_last, s1_rej, s1_byte_ok, s1_wild_ok;
	logic [BYTE_W-1:0]  s1_state;
	logic               s2_valid, s2_rej;

	logic               fifo_mem_q [OUT_DEPTH];
	logic [OUT_PW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [OUT_CW-1:0]  fifo_cnt_q, inflight_q;

	// Combinational
	act_t               act;
	logic               in_fire, out_fire, gives_result, is_lookup;
	logic [BYTE_W-1:0]  cur_eff, fin_state, next_cur;
	logic               rej_eff, fin_rej, next_rej, done;
	logic               pres_b, pres_w;
	logic               tran_we, acc_we;
	logic [TRAN_AW-1:0] tran_waddr, tran_ra_b, tran_ra_w;
	logic [TRAN_W-1:0]  tran_wdata, tran_rd_b, tran_rd_w;
	logic [ST_AW-1:0]   acc_waddr, acc_raddr;
	logic               acc_wdata, acc_rd;
	logic               s2_match;

	assign act          = act_t'(action);
	assign in_ready     = !clr_q && (inflight_q != OUT_CW'(OUT_DEPTH));
	assign in_fire      = in_valid && in_ready;
	assign out_valid    = (fifo_cnt_q != '0);
	assign out_fire     = out_valid && out_ready;
	assign matched      = fifo_mem_q[rd_ptr_q];
	assign is_lookup    = (act == ACT_MATCH) || (act == ACT_END);
	assign gives_result = (act == ACT_END) || ((act == ACT_MATCH) && is_last_byte);

	// Resolve the item in stage 1 from the two registered transition reads
	assign pres_b = s1_byte_ok && tran_rd_b[TRAN_W-1];
	assign pres_w = s1_wild_ok && tran_rd_w[TRAN_W-1];

	always_comb begin
		fin_state = s1_state;
		fin_rej   = s1_rej;
		if (!s1_end && !s1_rej) begin
			priority if (pres_b) begin
				fin_state = tran_rd_b[BYTE_W-1:0];
			end else if (pres_w) begin
				fin_state = tran_rd_w[BYTE_W-1:0];
			end else begin
				fin_rej = 1'b1;
			end
		end
	end

	assign done     = s1_end || s1_last;
	assign next_cur = done ? start_q : fin_state;
	assign next_rej = done ? 1'b0 : fin_rej;

	// Forward the stage-1 outcome to the item being taken now
	assign cur_eff = s1_valid ? next_cur : cur_q;
	assign rej_eff = s1_valid ? next_rej : rej_q;

	// Transition RAM: clearing pass, or a transition write
	always_comb begin
		tran_we    = 1'b0;
		tran_waddr = {table_state[ST_AW-1:0], table_symbol[SYM_AW-1:0]};
		tran_wdata = {table_entry_valid, table_next};
		if (clr_q) begin
			tran_we    = 1'b1;
			tran_waddr = clr_addr_q;
			tran_wdata = '0;
		end else if (in_fire && (act == ACT_WR_TRAN)) begin
			tran_we = state_ok(table_state) && symbol_ok(table_symbol);
		end
	end

	assign tran_ra_b = {cur_eff[ST_AW-1:0], text_byte[SYM_AW-1:0]};
	assign tran_ra_w = {cur_eff[ST_AW-1:0], wild_q[SYM_AW-1:0]};

	dfa_ram #(.WIDTH(TRAN_W), .DEPTH(TRAN_DEPTH)) u_tran_ram (
		.clk     (clk),
		.we      (tran_we),
		.waddr   (tran_waddr),
		.wdata   (tran_wdata),
		.raddr_a (tran_ra_b),
		.rdata_a (tran_rd_b),
		.raddr_b (tran_ra_w),
		.rdata_b (tran_rd_w)
	);

	// Accept-mark RAM: clearing pass, or an accept-mark write
	always_comb begin
		acc_we    = 1'b0;
		acc_waddr = table_state[ST_AW-1:0];
		acc_wdata = accept_value;
		if (clr_q) begin
			acc_we    = 1'b1;
			acc_waddr = clr_addr_q[ST_AW-1:0];
			acc_wdata = 1'b0;
		end else if (in_fire && (act == ACT_WR_ACCEPT)) begin
			acc_we = state_ok(table_state);
		end
	end

	assign acc_raddr = fin_state[ST_AW-1:0];

	dfa_ram #(.WIDTH(1), .DEPTH(ACC_DEPTH)) u_acc_ram (
		.clk     (clk),
		.we      (acc_we),
		.waddr   (acc_waddr),
		.wdata   (acc_wdata),
		.raddr_a (acc_raddr),
		.rdata_a (acc_rd),
		.raddr_b (acc_raddr),
		.rdata_b ()
	);

	assign s2_match = !s2_rej && acc_rd;

	// Clearing pass, configuration and string state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
			start_q    <= START_RESET;
			wild_q     <= WILDCARD_RESET;
			cur_q      <= START_RESET;
			rej_q      <= 1'b0;
		end else begin
			if (clr_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == '1) begin
					clr_q <= 1'b0;
				end
			end
			if (s1_valid) begin
				cur_q <= next_cur;
				rej_q <= next_rej;
			end
			if (cfg_we) begin
				unique case (reg_t'(cfg_index))
					REG_START_STATE: begin
						start_q <= cfg_data[BYTE_W-1:0];
						cur_q   <= cfg_data[BYTE_W-1:0];
						rej_q   <= 1'b0;
					end
					REG_WILDCARD: wild_q <= cfg_data[BYTE_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// Pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
			s2_valid <= 1'b0;
		end else begin
			s1_valid <= in_fire && is_lookup;
			s2_valid <= s1_valid && done;
		end
	end

	// Pipeline payload
	always_ff @(posedge clk) begin
		s1_end     <= (act == ACT_END);
		s1_last    <= is_last_byte;
		s1_state   <= cur_eff;
		s1_rej     <= rej_eff;
		s1_byte_ok <= state_ok(cur_eff) && symbol_ok(text_byte);
		s1_wild_ok <= state_ok(cur_eff) && symbol_ok(wild_q);
		s2_rej     <= fin_rej || !state_ok(fin_state);
	end

	// Result queue and in-flight count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			fifo_cnt_q <= '0;
			inflight_q <= '0;
		end else begin
			if (s2_valid) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (out_fire) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			fifo_cnt_q <= fifo_cnt_q + OUT_CW'(s2_valid) - OUT_CW'(out_fire);
			inflight_q <= inflight_q + OUT_CW'(in_fire && gives_result) - OUT_CW'(out_fire);
		end
	end

	always_ff @(posedge clk) begin
		if (s2_valid) begin
			fifo_mem_q[wr_ptr_q] <= s2_match;
		end
	end

endmodule
